// ===== src/lmre_pkg.sv =====
// Package for the label mask run encoder: types, codes and shared helpers.
`timescale 1ns / 1ps

package lmre_pkg;

    // Largest volume extent along any axis.
    localparam int MAX_DIM = 2048;

    localparam int DIM_W   = 12;   // extents, run ends and bounds
    localparam int POS_W   = 11;   // positions inside a ray, ray and plane indexes
    localparam int SKIP_W  = 23;
    localparam int PAIRS_W = 33;
    localparam int VOXEL_W = 34;
    localparam int LABEL_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AXIS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE = 3'd4;

    // Axis codes; the unused code behaves as the z axis.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_SPARE = 2'd3;

    localparam logic [1:0]         RESET_AXIS   = AXIS_X;
    localparam logic [LABEL_W-1:0] RESET_TARGET = 16'd1;
    localparam logic [DIM_W-1:0]   RESET_SIZE   = 12'd2048;

    typedef enum logic [1:0] {
        KIND_PAIR    = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]         axis;
        logic [LABEL_W-1:0] target_label;
        logic [DIM_W-1:0]   x_size;
        logic [DIM_W-1:0]   y_size;
        logic [DIM_W-1:0]   z_size;
    } cfg_t;

    // Everything that one voxel beat produces: up to one pair, one header
    // and one summary record.
    typedef struct packed {
        logic                  has_pair;
        logic                  has_hdr;
        logic                  has_sum;
        logic [POS_W-1:0]      pair_start;
        logic [DIM_W-1:0]      pair_end;
        logic [SKIP_W-1:0]     hdr_skip;
        logic [POS_W-1:0]      hdr_pairs;
        logic [2:0][DIM_W-1:0] box_lo;
        logic [2:0][DIM_W-1:0] box_hi;
        logic [PAIRS_W-1:0]    total_pairs;
        logic [VOXEL_W-1:0]    voxel_total;
    } rec_group_t;

    // An extent of zero acts as one, and one above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > MAX_DIM_V)
        begin
            r = MAX_DIM_V;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== src/lmre_cfg_regs.sv =====
// Configuration registers of the label mask run encoder.
`timescale 1ns / 1ps

module lmre_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [lmre_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [lmre_pkg::LABEL_W-1:0]    wr_data,
    output lmre_pkg::cfg_t                  cfg
);
    import lmre_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_AXIS:   cfg_next.axis         = wr_data[1:0];
                REG_TARGET: cfg_next.target_label = wr_data;
                REG_X_SIZE: cfg_next.x_size       = wr_data[DIM_W-1:0];
                REG_Y_SIZE: cfg_next.y_size       = wr_data[DIM_W-1:0];
                REG_Z_SIZE: cfg_next.z_size       = wr_data[DIM_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis         <= RESET_AXIS;
            cfg_reg.target_label <= RESET_TARGET;
            cfg_reg.x_size       <= RESET_SIZE;
            cfg_reg.y_size       <= RESET_SIZE;
            cfg_reg.z_size       <= RESET_SIZE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/lmre_core.sv =====
// Scan state and record generation for one voxel beat of the label mask run encoder.
`timescale 1ns / 1ps

module lmre_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lmre_pkg::cfg_t                cfg,
    input  logic                          step,
    input  logic [lmre_pkg::LABEL_W-1:0]  label_value,
    output lmre_pkg::rec_group_t          group
);
    import lmre_pkg::*;

    logic [POS_W-1:0]   along_reg, along_next;
    logic [POS_W-1:0]   ray_reg, ray_next;
    logic [POS_W-1:0]   plane_reg, plane_next;
    logic               open_reg, open_next;
    logic [POS_W-1:0]   begin_reg, begin_next;
    logic [POS_W-1:0]   first_reg, first_next;
    logic [SKIP_W-1:0]  empty_reg, empty_next;
    logic [POS_W-1:0]   rpairs_reg, rpairs_next;
    logic [PAIRS_W-1:0] ptotal_reg, ptotal_next;
    logic [VOXEL_W-1:0] vsum_reg, vsum_next;
    logic [2:0][DIM_W-1:0] lo_reg, lo_next;
    logic [2:0][DIM_W-1:0] hi_reg, hi_next;

    logic [1:0]       ax;
    logic [DIM_W-1:0] xs, ys, zs, d0n, d1n, d2n;
    logic [POS_W-1:0] lim0, lim1, lim2;
    logic [1:0]       d0idx, d1idx;
    logic             hit, ray_end, open_now, close, hdr, ray_wrap, vol_end;
    logic [DIM_W-1:0] pos_inc, run_end;
    logic [POS_W-1:0] begin_v, first_v, rpairs_mid;
    logic [PAIRS_W-1:0] ptotal_mid;
    logic [VOXEL_W-1:0] vsum_mid;
    logic [2:0][DIM_W-1:0] lo_mid, hi_mid;

    always_comb
    begin
        ax  = (cfg.axis == AXIS_SPARE) ? AXIS_Z : cfg.axis;
        xs  = eff_size(cfg.x_size);
        ys  = eff_size(cfg.y_size);
        zs  = eff_size(cfg.z_size);
        d2n = (ax == AXIS_X) ? xs : ((ax == AXIS_Y) ? ys : zs);
        d0n = (ax == AXIS_X) ? ys : xs;
        d1n = (ax == AXIS_Z) ? ys : zs;
        d0idx = (ax == AXIS_X) ? AXIS_Y : AXIS_X;
        d1idx = (ax == AXIS_Z) ? AXIS_Y : AXIS_Z;
        lim2 = POS_W'(d2n - DIM_W'(1));
        lim1 = POS_W'(d1n - DIM_W'(1));
        lim0 = POS_W'(d0n - DIM_W'(1));

        hit     = (label_value == cfg.target_label);
        ray_end = (along_reg >= lim2);
        pos_inc = {1'b0, along_reg} + DIM_W'(1);

        // A run opens on a hit with no run open and closes on a miss or at the ray end.
        open_now = open_reg | hit;
        begin_v  = open_reg ? begin_reg : along_reg;
        first_v  = (hit && !open_reg && rpairs_reg == '0) ? along_reg : first_reg;
        close    = open_now && (!hit || ray_end);
        run_end  = hit ? pos_inc : {1'b0, along_reg};

        rpairs_mid = close ? rpairs_reg + POS_W'(1) : rpairs_reg;
        ptotal_mid = close ? ptotal_reg + PAIRS_W'(1) : ptotal_reg;
        vsum_mid   = close ? vsum_reg + VOXEL_W'(run_end - {1'b0, begin_v}) : vsum_reg;
        hdr        = ray_end && (rpairs_mid != '0);

        // The three axes are touched by distinct sources, so each bound has one update.
        for (int i = 0; i < 3; i++)
        begin
            lo_mid[i] = lo_reg[i];
            hi_mid[i] = hi_reg[i];
            if (2'(i) == ax)
            begin
                if (close && {1'b0, first_v} < lo_reg[i])
                begin
                    lo_mid[i] = {1'b0, first_v};
                end
                if (close && run_end > hi_reg[i])
                begin
                    hi_mid[i] = run_end;
                end
            end
            else if (2'(i) == d0idx)
            begin
                if (hdr && {1'b0, plane_reg} < lo_reg[i])
                begin
                    lo_mid[i] = {1'b0, plane_reg};
                end
                if (hdr && {1'b0, plane_reg} > hi_reg[i])
                begin
                    hi_mid[i] = {1'b0, plane_reg};
                end
            end
            else if (2'(i) == d1idx)
            begin
                if (hdr && {1'b0, ray_reg} < lo_reg[i])
                begin
                    lo_mid[i] = {1'b0, ray_reg};
                end
                if (hdr && {1'b0, ray_reg} > hi_reg[i])
                begin
                    hi_mid[i] = {1'b0, ray_reg};
                end
            end
        end

        ray_wrap = ray_end && (ray_reg >= lim1);
        vol_end  = ray_wrap && (plane_reg >= lim0);

        along_next  = ray_end ? '0 : pos_inc[POS_W-1:0];
        ray_next    = ray_end ? (ray_wrap ? '0 : ray_reg + POS_W'(1)) : ray_reg;
        plane_next  = ray_wrap ? (vol_end ? '0 : plane_reg + POS_W'(1)) : plane_reg;
        open_next   = open_now && !close;
        begin_next  = begin_v;
        first_next  = first_v;
        rpairs_next = hdr ? '0 : rpairs_mid;

        if (vol_end)
        begin
            empty_next  = '0;
            ptotal_next = '0;
            vsum_next   = '0;
            for (int i = 0; i < 3; i++)
            begin
                lo_next[i] = MAX_DIM_V;
                hi_next[i] = '0;
            end
        end
        else
        begin
            empty_next  = ray_end ? (hdr ? '0 : empty_reg + SKIP_W'(1)) : empty_reg;
            ptotal_next = ptotal_mid;
            vsum_next   = vsum_mid;
            lo_next     = lo_mid;
            hi_next     = hi_mid;
        end

        group.has_pair    = close;
        group.has_hdr     = hdr;
        group.has_sum     = vol_end;
        group.pair_start  = begin_v;
        group.pair_end    = run_end;
        group.hdr_skip    = empty_reg;
        group.hdr_pairs   = rpairs_mid;
        group.box_lo      = lo_mid;
        group.box_hi      = hi_mid;
        group.total_pairs = ptotal_mid;
        group.voxel_total = vsum_mid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            along_reg  <= '0;
            ray_reg    <= '0;
            plane_reg  <= '0;
            open_reg   <= 1'b0;
            begin_reg  <= '0;
            first_reg  <= '0;
            empty_reg  <= '0;
            rpairs_reg <= '0;
            ptotal_reg <= '0;
            vsum_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= MAX_DIM_V;
                hi_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            along_reg  <= along_next;
            ray_reg    <= ray_next;
            plane_reg  <= plane_next;
            open_reg   <= open_next;
            begin_reg  <= begin_next;
            first_reg  <= first_next;
            empty_reg  <= empty_next;
            rpairs_reg <= rpairs_next;
            ptotal_reg <= ptotal_next;
            vsum_reg   <= vsum_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
        end
    end

`ifndef SYNTHESIS
    // An open run always lies behind the first position of its ray.
    a_open_not_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (along_reg != '0))
        else $error("run open at ray start");

    // A summary can only come at the end of a ray.
    a_sum_at_ray_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && vol_end) |-> ray_end)
        else $error("summary away from ray end");
`endif

endmodule

// ===== src/lmre_record_out.sv =====
// Result register of the label mask run encoder: holds one record group and sends it beat by beat.
`timescale 1ns / 1ps

module lmre_record_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  lmre_pkg::rec_group_t          group,
    output logic                          ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    record_kind,
    output logic [lmre_pkg::SKIP_W-1:0]   first_value,
    output logic [lmre_pkg::DIM_W-1:0]    second_value,
    output logic [lmre_pkg::DIM_W-1:0]    box_x_low,
    output logic [lmre_pkg::DIM_W-1:0]    box_x_high,
    output logic [lmre_pkg::DIM_W-1:0]    box_y_low,
    output logic [lmre_pkg::DIM_W-1:0]    box_y_high,
    output logic [lmre_pkg::DIM_W-1:0]    box_z_low,
    output logic [lmre_pkg::DIM_W-1:0]    box_z_high,
    output logic [lmre_pkg::PAIRS_W-1:0]  total_pairs,
    output logic [lmre_pkg::VOXEL_W-1:0]  voxel_total,
    output logic                          last
);
    import lmre_pkg::*;

    rec_group_t grp_reg;
    logic [2:0] pend_reg, pend_next;   // pending records: pair, header, summary
    logic [2:0] sent;
    logic       beat;
    kind_t      kind;

    assign beat      = out_valid && !out_stall;
    assign out_valid = (pend_reg != '0);
    assign last      = $onehot(pend_reg);
    assign ready     = (pend_reg == '0) || (last && !out_stall);

    always_comb
    begin
        if (pend_reg[0])
        begin
            kind = KIND_PAIR;
            sent = 3'b001;
        end
        else if (pend_reg[1])
        begin
            kind = KIND_HEADER;
            sent = 3'b010;
        end
        else
        begin
            kind = KIND_SUMMARY;
            sent = 3'b100;
        end

        pend_next = beat ? (pend_reg & ~sent) : pend_reg;
        if (load)
        begin
            pend_next = {group.has_sum, group.has_hdr, group.has_pair};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= group;
        end
    end

    always_comb
    begin
        record_kind  = kind;
        first_value  = '0;
        second_value = '0;
        box_x_low    = '0;
        box_x_high   = '0;
        box_y_low    = '0;
        box_y_high   = '0;
        box_z_low    = '0;
        box_z_high   = '0;
        total_pairs  = '0;
        voxel_total  = '0;
        case (kind)
            KIND_PAIR:
            begin
                first_value  = SKIP_W'(grp_reg.pair_start);
                second_value = grp_reg.pair_end;
            end
            KIND_HEADER:
            begin
                first_value  = grp_reg.hdr_skip;
                second_value = {1'b0, grp_reg.hdr_pairs};
            end
            KIND_SUMMARY:
            begin
                box_x_low   = grp_reg.box_lo[0];
                box_x_high  = grp_reg.box_hi[0];
                box_y_low   = grp_reg.box_lo[1];
                box_y_high  = grp_reg.box_hi[1];
                box_z_low   = grp_reg.box_lo[2];
                box_z_high  = grp_reg.box_hi[2];
                total_pairs = grp_reg.total_pairs;
                voxel_total = grp_reg.voxel_total;
            end
            default:
            begin
                first_value = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A new group is taken only when the current one is gone by the same edge.
    a_load_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ready)
        else $error("record group overwritten");

    // A beat without last leaves more records of the group waiting.
    a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && !last) |=> out_valid)
        else $error("record group cut short");

    // The summary always closes its group.
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && record_kind == KIND_SUMMARY) |-> last)
        else $error("summary not last");
`endif

endmodule

// ===== src/label_mask_run_encoder_top.sv =====
// Top level of the label mask run encoder.
`timescale 1ns / 1ps

// Path: input register, then scan logic, then result register, from which records leave.
// Throughput: one voxel beat per cycle while each beat yields at most one record and
// out_stall stays low; a beat that yields two or three records holds the input until the
// last of them leaves, since the one result register sends records one at a time.
// Reset: rst_n clears the scan counters, totals and bounds and loads the register defaults
// (axis x, target label 1, all extents 2048); no clearing pass is needed.
module label_mask_run_encoder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lmre_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lmre_pkg::LABEL_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lmre_pkg::LABEL_W-1:0]        label_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          record_kind,
    output logic [lmre_pkg::SKIP_W-1:0]         first_value,
    output logic [lmre_pkg::DIM_W-1:0]          second_value,
    output logic [lmre_pkg::DIM_W-1:0]          box_x_low,
    output logic [lmre_pkg::DIM_W-1:0]          box_x_high,
    output logic [lmre_pkg::DIM_W-1:0]          box_y_low,
    output logic [lmre_pkg::DIM_W-1:0]          box_y_high,
    output logic [lmre_pkg::DIM_W-1:0]          box_z_low,
    output logic [lmre_pkg::DIM_W-1:0]          box_z_high,
    output logic [lmre_pkg::PAIRS_W-1:0]        total_pairs,
    output logic [lmre_pkg::VOXEL_W-1:0]        voxel_total,
    output logic                                last
);
    import lmre_pkg::*;

    cfg_t       cfg;
    rec_group_t group;
    logic       ready;
    logic       step;
    logic       in_beat;

    // The input register holds one voxel label. It moves into the scan logic as soon as
    // the result register can take the records the voxel produces, so a fresh beat is
    // accepted in the same cycle that the held one moves on.
    logic                 vld_reg, vld_next;
    logic [LABEL_W-1:0]   label_reg;

    assign step     = vld_reg && ready;
    assign in_stall = vld_reg && !ready;
    assign in_beat  = in_valid && !in_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_beat)
        begin
            vld_next = 1'b1;
        end
        else if (step)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            label_reg <= label_value;
        end
    end

    lmre_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_write),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Scan state and record generation: compares, counters and adds for one voxel.
    lmre_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step        (step),
        .label_value (label_reg),
        .group       (group)
    );

    // Result register: pair, header and summary leave in that order, last on the final one.
    lmre_record_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step),
        .group        (group),
        .ready        (ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .record_kind  (record_kind),
        .first_value  (first_value),
        .second_value (second_value),
        .box_x_low    (box_x_low),
        .box_x_high   (box_x_high),
        .box_y_low    (box_y_low),
        .box_y_high   (box_y_high),
        .box_z_low    (box_z_low),
        .box_z_high   (box_z_high),
        .total_pairs  (total_pairs),
        .voxel_total  (voxel_total),
        .last         (last)
    );

endmodule

// ===== sim/label_mask_run_encoder_top_tb.sv =====
// Self-checking label mask run encoder bench: directed table, hold-off, then random volumes.
`timescale 1ns / 1ps

module label_mask_run_encoder_top_tb;

    import lmre_pkg::*;

    // Settle time before a register write. A voxel beat can yield nothing, so
    // the block may still be working after the last expected record has left.
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int PRESSURE_ITEMS = 24;
    localparam int RANDOM_ITEMS   = 370;
    localparam int CYCLE_LIMIT    = 400000;

    // One record as it leaves the block.
    typedef struct packed {
        kind_t              kind;
        logic [SKIP_W-1:0]  first;
        logic [DIM_W-1:0]   second;
        logic [DIM_W-1:0]   x_lo;
        logic [DIM_W-1:0]   x_hi;
        logic [DIM_W-1:0]   y_lo;
        logic [DIM_W-1:0]   y_hi;
        logic [DIM_W-1:0]   z_lo;
        logic [DIM_W-1:0]   z_hi;
        logic [PAIRS_W-1:0] pairs;
        logic [VOXEL_W-1:0] voxels;
        logic               last;
    } record_t;

    // Rows of the directed table: a register write or a voxel beat. A voxel row
    // relies on the scan model, expects no record, or carries its expected pair typed in.
    typedef enum logic {ROW_WRITE, ROW_VOXEL} row_kind_t;
    typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_PAIR} row_check_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [2:0]         index;
        logic [LABEL_W-1:0] value;
        row_check_t         check;
        logic [SKIP_W-1:0]  first;
        logic [DIM_W-1:0]   second;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LABEL_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [LABEL_W-1:0]   label_value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           record_kind;
    logic [SKIP_W-1:0]    first_value;
    logic [DIM_W-1:0]     second_value;
    logic [DIM_W-1:0]     box_x_low;
    logic [DIM_W-1:0]     box_x_high;
    logic [DIM_W-1:0]     box_y_low;
    logic [DIM_W-1:0]     box_y_high;
    logic [DIM_W-1:0]     box_z_low;
    logic [DIM_W-1:0]     box_z_high;
    logic [PAIRS_W-1:0]   total_pairs;
    logic [VOXEL_W-1:0]   voxel_total;
    logic                 last;

    // Shadow of the register file and of the scan state inside the block.
    logic [1:0]           trace_axis;
    logic [LABEL_W-1:0]   match_label;
    logic [DIM_W-1:0]     extent [3];
    logic [POS_W-1:0]     scan_pos;
    logic [POS_W-1:0]     scan_ray;
    logic [POS_W-1:0]     scan_plane;
    bit                   run_live;
    logic [POS_W-1:0]     run_start;
    logic [POS_W-1:0]     ray_lead;
    logic [SKIP_W-1:0]    skipped_rays;
    logic [POS_W-1:0]     ray_runs;
    logic [PAIRS_W-1:0]   runs_seen;
    logic [VOXEL_W-1:0]   voxels_seen;
    logic [DIM_W-1:0]     box_lo [3];
    logic [DIM_W-1:0]     box_hi [3];

    record_t              pending_records [$];
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    int                   scan_items = 0;
    bit                   steady = 1'b0;
    int                   hold_asked = 0;
    int                   hold_served = 0;
    int                   hold_left = 0;

    label_mask_run_encoder_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .label_value  (label_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .record_kind  (record_kind),
        .first_value  (first_value),
        .second_value (second_value),
        .box_x_low    (box_x_low),
        .box_x_high   (box_x_high),
        .box_y_low    (box_y_low),
        .box_y_high   (box_y_high),
        .box_z_low    (box_z_low),
        .box_z_high   (box_z_high),
        .total_pairs  (total_pairs),
        .voxel_total  (voxel_total),
        .last         (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Extent as the block uses it: zero acts as one, anything past the
    // maximum is clipped to the maximum.
    function automatic int span(input logic [DIM_W-1:0] v);
        return (v == '0) ? 1 : ((int'(v) > MAX_DIM) ? MAX_DIM : int'(v));
    endfunction

    function automatic void grow_box(input int k, input int lo, input int hi);
        if (lo < int'(box_lo[k]))
        begin
            box_lo[k] = DIM_W'(lo);
        end
        if (hi > int'(box_hi[k]))
        begin
            box_hi[k] = DIM_W'(hi);
        end
    endfunction

    // Totals, bounds and the skipped-ray count start over with every volume.
    function automatic void clear_totals();
        int k;
        runs_seen = '0;
        voxels_seen = '0;
        skipped_rays = '0;
        for (k = 0; k < 3; k++)
        begin
            box_lo[k] = MAX_DIM_V;
            box_hi[k] = '0;
        end
    endfunction

    function automatic record_t make_record(input kind_t kind, input int a, input int b,
                                            input bit totals);
        record_t r;
        r = '0;
        r.kind = kind;
        r.first = SKIP_W'(a);
        r.second = DIM_W'(b);
        if (totals)
        begin
            r.x_lo = box_lo[0];
            r.x_hi = box_hi[0];
            r.y_lo = box_lo[1];
            r.y_hi = box_hi[1];
            r.z_lo = box_lo[2];
            r.z_hi = box_hi[2];
            r.pairs = runs_seen;
            r.voxels = voxels_seen;
        end
        return r;
    endfunction

    // Advances the scan by one voxel and, when keep is set, queues the records
    // it closes: a run pair, then a ray header, then the volume summary.
    function automatic void encode_voxel(input logic [LABEL_W-1:0] lbl, input bit keep);
        int along_n;
        int plane_n;
        int ray_n;
        int along_k;
        int plane_k;
        int ray_k;
        int pos;
        int stop;
        int n;
        int i;
        bit hit;
        bit ray_end;
        bit vol_end;
        record_t made [3];

        // The spare axis code traces along z.
        if (trace_axis == AXIS_X)
        begin
            along_k = 0;
            plane_k = 1;
            ray_k = 2;
        end
        else if (trace_axis == AXIS_Y)
        begin
            along_k = 1;
            plane_k = 0;
            ray_k = 2;
        end
        else
        begin
            along_k = 2;
            plane_k = 0;
            ray_k = 1;
        end
        along_n = span(extent[along_k]);
        plane_n = span(extent[plane_k]);
        ray_n = span(extent[ray_k]);

        hit = (lbl == match_label);
        pos = int'(scan_pos);
        // At or past the last position counts as the ray end, which also
        // covers an extent shrunk in the middle of a volume.
        ray_end = (pos >= along_n - 1);
        n = 0;

        if (hit && !run_live)
        begin
            run_live = 1'b1;
            run_start = POS_W'(pos);
            if (ray_runs == '0)
            begin
                ray_lead = POS_W'(pos);
            end
        end
        if (run_live && (!hit || ray_end))
        begin
            // A run still open on the last voxel ends one past it.
            stop = hit ? pos + 1 : pos;
            made[n] = make_record(KIND_PAIR, int'(run_start), stop, 1'b0);
            n++;
            voxels_seen = voxels_seen + VOXEL_W'(stop - int'(run_start));
            runs_seen = runs_seen + 1'b1;
            ray_runs = ray_runs + 1'b1;
            grow_box(along_k, int'(ray_lead), stop);
            run_live = 1'b0;
        end

        if (!ray_end)
        begin
            scan_pos = POS_W'(pos + 1);
        end
        else
        begin
            vol_end = 1'b0;
            if (ray_runs != '0)
            begin
                made[n] = make_record(KIND_HEADER, int'(skipped_rays), int'(ray_runs), 1'b0);
                n++;
                grow_box(plane_k, int'(scan_plane), int'(scan_plane));
                grow_box(ray_k, int'(scan_ray), int'(scan_ray));
                skipped_rays = '0;
                ray_runs = '0;
            end
            else
            begin
                skipped_rays = skipped_rays + 1'b1;
            end
            scan_pos = '0;
            if (int'(scan_ray) >= ray_n - 1)
            begin
                scan_ray = '0;
                if (int'(scan_plane) >= plane_n - 1)
                begin
                    scan_plane = '0;
                    vol_end = 1'b1;
                end
                else
                begin
                    scan_plane = scan_plane + 1'b1;
                end
            end
            else
            begin
                scan_ray = scan_ray + 1'b1;
            end
            // Empty rays after the last header of a volume end up in no record.
            if (vol_end)
            begin
                made[n] = make_record(KIND_SUMMARY, 0, 0, 1'b1);
                n++;
                clear_totals();
            end
        end

        if (n > 0)
        begin
            made[n - 1].last = 1'b1;
        end
        if (keep)
        begin
            for (i = 0; i < n; i++)
            begin
                pending_records.push_back(made[i]);
            end
        end
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [VOXEL_W-1:0] got,
                               input logic [VOXEL_W-1:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic take_record();
        record_t want;
        if (pending_records.size() == 0)
        begin
            report_mismatch($sformatf("record kind %0d with nothing expected", record_kind));
        end
        else
        begin
            want = pending_records.pop_front();
            check_field("record_kind", record_kind, want.kind);
            check_field("first_value", first_value, want.first);
            check_field("second_value", second_value, want.second);
            check_field("box_x_low", box_x_low, want.x_lo);
            check_field("box_x_high", box_x_high, want.x_hi);
            check_field("box_y_low", box_y_low, want.y_lo);
            check_field("box_y_high", box_y_high, want.y_hi);
            check_field("box_z_low", box_z_low, want.z_lo);
            check_field("box_z_high", box_z_high, want.z_hi);
            check_field("total_pairs", total_pairs, want.pairs);
            check_field("voxel_total", voxel_total, want.voxels);
            check_field("last", last, want.last);
        end
    endtask

    // Output side. A beat is taken at an edge where out_valid is high and the
    // stall we drove before that edge is low; then the next stall is chosen.
    // A long hold-off, asked for by the stimulus, lets the block fill up and
    // push back on its input while the sender keeps offering beats.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            take_record();
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served = hold_served + 1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !steady && ($urandom_range(0, 99) < 11);
        end
    end

    // Offers one voxel beat, after a random gap, and returns at the edge that
    // accepts it. Valid and the label stay put while the block stalls.
    task automatic send_voxel(input logic [LABEL_W-1:0] lbl);
        while (!steady && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        label_value <= lbl;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
    endtask

    // Registers change only while the block is idle: nothing offered, every
    // expected record gone, and a few cycles more for beats that yield none.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_records.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The write enable is left high so that back-to-back writes need no
    // second assignment in one step; the caller lowers it afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LABEL_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_AXIS:   trace_axis = val[1:0];
            REG_TARGET: match_label = val;
            REG_X_SIZE: extent[0] = val[DIM_W-1:0];
            REG_Y_SIZE: extent[1] = val[DIM_W-1:0];
            REG_Z_SIZE: extent[2] = val[DIM_W-1:0];
            default:    ;
        endcase
    endtask

    function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [LABEL_W-1:0] val);
        script_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.index = idx;
        r.value = val;
        r.check = CHECK_MODEL;
        return r;
    endfunction

    function automatic script_row_t voxel_row(input logic [LABEL_W-1:0] lbl,
                                              input row_check_t check,
                                              input int a, input int b);
        script_row_t r;
        r = '0;
        r.kind = ROW_VOXEL;
        r.value = lbl;
        r.check = check;
        r.first = SKIP_W'(a);
        r.second = DIM_W'(b);
        return r;
    endfunction

    // One random phase: new register settings, then whole volumes of voxels
    // with runs clustered around the target label. A broken phase stops in
    // the middle of a volume, so the next phase resizes a volume in flight.
    task automatic random_phase(input bit broken);
        int k;
        int along_k;
        int voxels;
        int count;
        bit in_run;
        logic [LABEL_W-1:0] lbl;
        logic [DIM_W-1:0] sz [3];
        logic [1:0] ax;

        settle_block();
        ax = 2'($urandom_range(0, 3));
        for (k = 0; k < 3; k++)
        begin
            sz[k] = DIM_W'($urandom_range(1, 4));
        end
        along_k = (ax == AXIS_X) ? 0 : ((ax == AXIS_Y) ? 1 : 2);
        case ($urandom_range(0, 9))
            0:       sz[$urandom_range(0, 2)] = '0;
            1:       sz[along_k] = DIM_W'($urandom_range(8, 24));
            default: ;
        endcase
        write_reg(REG_AXIS, LABEL_W'(ax));
        write_reg(REG_TARGET, ($urandom_range(0, 1) != 0) ? LABEL_W'($urandom)
                                                          : LABEL_W'($urandom_range(0, 3)));
        write_reg(REG_X_SIZE, LABEL_W'(sz[0]));
        write_reg(REG_Y_SIZE, LABEL_W'(sz[1]));
        write_reg(REG_Z_SIZE, LABEL_W'(sz[2]));
        if ($urandom_range(0, 3) == 0)
        begin
            // Indexes past the register list must leave everything alone.
            write_reg(CFG_IDX_W'($urandom_range(5, 7)), LABEL_W'($urandom));
        end
        cfg_write <= 1'b0;

        voxels = span(sz[0]) * span(sz[1]) * span(sz[2]) * $urandom_range(1, 2);
        if (broken)
        begin
            voxels = $urandom_range(1, voxels);
        end
        // The random part stops at its item budget.
        if (voxels > RANDOM_ITEMS - scan_items)
        begin
            voxels = RANDOM_ITEMS - scan_items;
        end
        in_run = 1'b0;
        for (count = 0; count < voxels; count++)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                in_run = !in_run;
            end
            lbl = in_run ? match_label : LABEL_W'($urandom);
            send_voxel(lbl);
            encode_voxel(lbl, 1'b1);
            scan_items++;
        end
    endtask

    initial
    begin
        script_row_t script [$];
        record_t typed;
        bit writing;
        int phase;
        int count;
        logic [LABEL_W-1:0] lbl;

        // Register defaults and a clean scan, as reset leaves the block.
        trace_axis = RESET_AXIS;
        match_label = RESET_TARGET;
        extent[0] = RESET_SIZE;
        extent[1] = RESET_SIZE;
        extent[2] = RESET_SIZE;
        scan_pos = '0;
        scan_ray = '0;
        scan_plane = '0;
        run_live = 1'b0;
        run_start = '0;
        ray_lead = '0;
        ray_runs = '0;
        clear_totals();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. It opens under the reset settings, shrinks the
        // volume while a run is open past the new extent, then covers a one
        // voxel volume with all three records, the spare axis code, a zero
        // extent, both extreme target labels and unused register indexes.
        script = '{
            voxel_row(16'h0000, CHECK_NONE, 0, 0),
            voxel_row(16'h0001, CHECK_NONE, 0, 0),
            voxel_row(16'h0001, CHECK_NONE, 0, 0),
            voxel_row(16'hFFFF, CHECK_PAIR, 1, 3),
            voxel_row(16'h0001, CHECK_NONE, 0, 0),
            cfg_row(REG_X_SIZE, 16'd4),
            cfg_row(REG_Y_SIZE, 16'd2),
            cfg_row(REG_Z_SIZE, 16'd1),
            voxel_row(16'h0001, CHECK_MODEL, 0, 0),
            voxel_row(16'h0000, CHECK_MODEL, 0, 0),
            voxel_row(16'h0000, CHECK_MODEL, 0, 0),
            voxel_row(16'h0000, CHECK_MODEL, 0, 0),
            voxel_row(16'h0000, CHECK_MODEL, 0, 0),
            cfg_row(REG_TARGET, 16'h0000),
            cfg_row(REG_AXIS, 16'(AXIS_SPARE)),
            cfg_row(REG_X_SIZE, 16'd1),
            cfg_row(REG_Y_SIZE, 16'd1),
            cfg_row(REG_Z_SIZE, 16'd0),
            voxel_row(16'h0000, CHECK_MODEL, 0, 0),
            cfg_row(REG_TARGET, 16'hFFFF),
            cfg_row(3'd5, 16'h0003),
            cfg_row(3'd7, 16'h0000),
            cfg_row(REG_AXIS, 16'(AXIS_Y)),
            cfg_row(REG_Y_SIZE, 16'd3),
            cfg_row(REG_Z_SIZE, 16'd2),
            voxel_row(16'hFFFF, CHECK_MODEL, 0, 0),
            voxel_row(16'hFFFF, CHECK_MODEL, 0, 0),
            voxel_row(16'h0000, CHECK_MODEL, 0, 0),
            voxel_row(16'h0000, CHECK_MODEL, 0, 0),
            voxel_row(16'hFFFF, CHECK_MODEL, 0, 0),
            voxel_row(16'hFFFF, CHECK_MODEL, 0, 0)
        };

        writing = 1'b0;
        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                if (!writing)
                begin
                    settle_block();
                    writing = 1'b1;
                end
                write_reg(script[i].index, script[i].value);
            end
            else
            begin
                if (writing)
                begin
                    cfg_write <= 1'b0;
                    writing = 1'b0;
                end
                send_voxel(script[i].value);
                // The scan state always advances; typed rows replace what
                // would be queued with the outcome written in the table.
                encode_voxel(script[i].value, script[i].check == CHECK_MODEL);
                if (script[i].check == CHECK_PAIR)
                begin
                    typed = '0;
                    typed.kind = KIND_PAIR;
                    typed.first = script[i].first;
                    typed.second = script[i].second;
                    typed.last = 1'b1;
                    pending_records.push_back(typed);
                end
            end
        end

        // Long output hold-off under the last table settings. The receiver
        // stalls while the sender keeps offering beats, many of which close runs,
        // so the result and input registers fill and the input stalls.
        settle_block();
        hold_asked++;
        for (count = 0; count < PRESSURE_ITEMS; count++)
        begin
            lbl = (count % 3 == 1) ? ~match_label : match_label;
            send_voxel(lbl);
            encode_voxel(lbl, 1'b1);
        end

        // Random part. A few phases run with no gaps on either side.
        phase = 0;
        while (scan_items < RANDOM_ITEMS)
        begin
            steady = (phase >= 3 && phase <= 5);
            random_phase($urandom_range(0, 4) == 0);
            phase++;
        end

        steady = 1'b0;
        in_valid <= 1'b0;
        while (pending_records.size() != 0)
        begin
            @(posedge clk);
        end
        // A few more cycles catch any record the block sends unasked.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/lmre_pkg.sv
src/lmre_cfg_regs.sv
src/lmre_core.sv
src/lmre_record_out.sv
src/label_mask_run_encoder_top.sv
sim/label_mask_run_encoder_top_tb.sv
